// ===== sv/biquad_cascade_equalizer_assert.svh =====
// Assertion macros shared by the equalizer checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef BIQUAD_CASCADE_EQUALIZER_ASSERT_SVH
`define BIQUAD_CASCADE_EQUALIZER_ASSERT_SVH

// same-cycle implication
`define BQE_AP_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define BQE_AP_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/bqe_pkg.sv =====
// Package for the biquad cascade equalizer: sizes, codes, beat and link types,
// and the shared saturation function. No dependencies.
package bqe_pkg;

    localparam int NUM_BANDS      = 16;
    localparam int MAX_CHANNELS   = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int NUM_COEF       = 5;
    localparam int CH_W           = 3;
    localparam int BAND_W         = 4;
    localparam int SEL_W          = 3;
    localparam int GAIN_BITS      = 24;
    localparam int GAIN_FRAC      = 20;
    localparam int CNT_W          = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_W          = 24;

    localparam int PROD_W  = COEF_BITS + SAMPLE_BITS;     // one section product
    localparam int ACC_W   = PROD_W + 3;                  // sum of five products
    localparam int SHR_W   = ACC_W - COEF_FRAC_BITS;
    localparam int GPROD_W = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int GSHR_W  = GPROD_W - GAIN_FRAC;
    localparam int SAT_W   = 40;

    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC);
    localparam logic [CNT_W-1:0]     CC_RESET   = CNT_W'(2);

    localparam logic signed [ACC_W-1:0]   RND_COEF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [GPROD_W-1:0] RND_GAIN = GPROD_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [SAT_W-1:0]   SAT_HI   = SAT_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0]   SAT_LO   = -SAT_HI - SAT_W'(1);

    // opcodes
    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // coefficient selects
    localparam logic [SEL_W-1:0] C_B0 = 3'd0;
    localparam logic [SEL_W-1:0] C_B1 = 3'd1;
    localparam logic [SEL_W-1:0] C_B2 = 3'd2;
    localparam logic [SEL_W-1:0] C_A1 = 3'd3;
    localparam logic [SEL_W-1:0] C_A2 = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EQ_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MASK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMP_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic [CH_W-1:0]               channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [BAND_W-1:0]             band;
        logic [SEL_W-1:0]              coef_select;
        logic signed [COEF_BITS-1:0]   coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CH_W-1:0]               channel_out;
    } t_out_item;

    typedef struct packed {
        logic                          valid;
        logic [CH_W-1:0]               ch;
        logic signed [SAMPLE_BITS-1:0] y;
    } t_link;

    typedef struct packed {
        logic                        coef_we;
        logic [SEL_W-1:0]            coef_sel;
        logic signed [COEF_BITS-1:0] coef_val;
        logic                        hist_clr;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } t_hist;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== sv/bqe_cell.sv =====
// One biquad band section of the cascade: coefficients, per-channel history,
// three-stage multiply/sum/round pipeline. Depends on bqe_pkg.
module bqe_cell import bqe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_active,
    input  t_link     i_link,
    output t_link     o_link
);

    logic signed [COEF_BITS-1:0] r_coef [NUM_COEF];
    t_hist                       r_hist [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]     r_hv;

    // stage 1: products
    logic                          r1_v;
    logic                          r1_act;
    logic [CH_W-1:0]               r1_ch;
    logic signed [SAMPLE_BITS-1:0] r1_x;
    t_hist                         r1_h;
    logic signed [PROD_W-1:0]      r1_p [NUM_COEF];

    // stage 2: partial sums
    logic                          r2_v;
    logic                          r2_act;
    logic [CH_W-1:0]               r2_ch;
    logic signed [SAMPLE_BITS-1:0] r2_x;
    t_hist                         r2_h;
    logic signed [ACC_W-1:0]       r2_s01;
    logic signed [ACC_W-1:0]       r2_s23;
    logic signed [ACC_W-1:0]       r2_p4;

    t_link r_out;

    t_hist                         h_rd;
    logic signed [PROD_W-1:0]      n_p [NUM_COEF];
    logic signed [ACC_W-1:0]       acc;
    logic signed [SHR_W-1:0]       shv;
    logic signed [SAMPLE_BITS-1:0] ysat;
    t_hist                         n_hist;

    always_comb begin
        h_rd = r_hv[i_link.ch] ? r_hist[i_link.ch] : '0;
        n_p[0] = r_coef[0] * $signed(i_link.y);
        n_p[1] = r_coef[1] * h_rd.x1;
        n_p[2] = r_coef[2] * h_rd.x2;
        n_p[3] = r_coef[3] * h_rd.y1;
        n_p[4] = r_coef[4] * h_rd.y2;
    end

    always_comb begin
        acc    = r2_s01 + r2_s23 - r2_p4 + RND_COEF;
        shv    = $signed(acc[ACC_W-1:COEF_FRAC_BITS]);
        ysat   = sat_sample(SAT_W'(shv));
        n_hist = '{x1: r2_x, x2: r2_h.x1, y1: ysat, y2: r2_h.y1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_ctl.coef_we) begin
            unique case (i_ctl.coef_sel)
                C_B0:    r_coef[0] <= i_ctl.coef_val;
                C_B1:    r_coef[1] <= i_ctl.coef_val;
                C_B2:    r_coef[2] <= i_ctl.coef_val;
                C_A1:    r_coef[3] <= i_ctl.coef_val;
                C_A2:    r_coef[4] <= i_ctl.coef_val;
                default: ;
            endcase
        end
    end

    // history valid bits: cleared entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= '0;
        end else if (i_ctl.hist_clr) begin
            r_hv <= '0;
        end else if (r2_v && r2_act) begin
            r_hv[r2_ch] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_v && r2_act) begin
            r_hist[r2_ch] <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r1_v        <= i_link.valid;
            r2_v        <= r1_v;
            r_out.valid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_act <= i_active;
        r1_ch  <= i_link.ch;
        r1_x   <= i_link.y;
        r1_h   <= h_rd;
        for (int k = 0; k < NUM_COEF; k++) begin
            r1_p[k] <= n_p[k];
        end
        r2_act <= r1_act;
        r2_ch  <= r1_ch;
        r2_x   <= r1_x;
        r2_h   <= r1_h;
        r2_s01 <= ACC_W'(r1_p[0]) + ACC_W'(r1_p[1]);
        r2_s23 <= ACC_W'(r1_p[2]) - ACC_W'(r1_p[3]);
        r2_p4  <= ACC_W'(r1_p[4]);
        r_out.ch <= r2_ch;
        r_out.y  <= r2_act ? ysat : r2_x;
    end

    assign o_link = r_out;

endmodule

// ===== sv/bqe_gain.sv =====
// Preamp gain stage at the end of the cascade: Q4.20 multiply, round, saturate.
// Depends on bqe_pkg.
module bqe_gain import bqe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [GAIN_BITS-1:0] i_gain,
    input  t_link                i_link,
    output t_link                o_link
);

    logic                      r_v;
    logic [CH_W-1:0]           r_ch;
    logic signed [GPROD_W-1:0] r_p;
    t_link                     r_out;

    logic signed [GPROD_W-1:0] rnd;
    logic signed [GSHR_W-1:0]  shv;

    always_comb begin
        rnd = r_p + RND_GAIN;
        shv = $signed(rnd[GPROD_W-1:GAIN_FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_v         <= i_link.valid;
            r_out.valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= i_link.ch;
        r_p      <= $signed(i_link.y) * $signed({1'b0, i_gain});
        r_out.ch <= r_ch;
        r_out.y  <= sat_sample(SAT_W'(shv));
    end

    assign o_link = r_out;

endmodule

// ===== sv/biquad_cascade_equalizer.sv =====
// Biquad cascade equalizer: a filtered sample walks a row of NUM_BANDS band
// cells, passing through every cell's pipeline whether the band is active or
// not, then through the preamp gain stage, after which the result is held;
// one sample is in the cascade at a time. Passthrough and dropped samples,
// coefficient writes and history clears do not enter the cascade.
// The result sits in an output register, so the next beat is taken while it
// waits. Depends on bqe_pkg, bqe_cell, bqe_gain.
module biquad_cascade_equalizer import bqe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out
);

    logic                 r_en;
    logic [NUM_BANDS-1:0] r_mask;
    logic [GAIN_BITS-1:0] r_gain;
    logic [CNT_W-1:0]     r_cc;

    logic      r_busy;
    logic      r_chain;
    t_link     r_entry;
    logic      r_hold_v;
    t_out_item r_hold;
    logic      r_out_v;
    t_out_item r_out;

    t_link     w_link [NUM_BANDS+1];
    t_link     w_gain;
    t_cell_ctl w_ctl  [NUM_BANDS];

    logic accept, is_filt, drop, pass, to_chain, to_hold, move;

    always_comb begin
        accept   = i_in_valid && o_in_ready;
        is_filt  = i_in.opcode == OP_FILTER;
        drop     = {1'b0, i_in.channel} >= r_cc;
        pass     = !r_en || (r_mask == '0 && r_gain == GAIN_UNITY);
        to_chain = accept && is_filt && !drop && !pass;
        to_hold  = accept && is_filt && !drop && pass;
        move     = r_hold_v && (!r_out_v || i_out_ready);
    end

    assign o_in_ready  = !r_busy && !r_hold_v;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b1;
            r_mask <= '0;
            r_gain <= GAIN_UNITY;
            r_cc   <= CC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EQ_ENABLE:     r_en   <= i_cfg_data[0];
                CFG_BAND_MASK:     r_mask <= i_cfg_data[NUM_BANDS-1:0];
                CFG_PREAMP_GAIN:   r_gain <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CHANNEL_COUNT: r_cc   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // busy covers the beat after every accept, and the whole cascade trip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_chain <= 1'b0;
        end else if (accept) begin
            r_busy  <= 1'b1;
            r_chain <= to_chain;
        end else if (r_busy && !r_chain) begin
            r_busy <= 1'b0;
        end else if (w_gain.valid) begin
            r_busy  <= 1'b0;
            r_chain <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= to_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.ch <= i_in.channel;
        r_entry.y  <= i_in.sample_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (to_hold || w_gain.valid) begin
            r_hold_v <= 1'b1;
        end else if (move) begin
            r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (to_hold) begin
            r_hold <= '{sample_out: i_in.sample_in, channel_out: i_in.channel};
        end else if (w_gain.valid) begin
            r_hold <= '{sample_out: w_gain.y, channel_out: w_gain.ch};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (move) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= r_hold;
        end
    end

    assign w_link[0] = r_entry;

    for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
        always_comb begin
            w_ctl[b].coef_we  = accept && i_in.opcode == OP_COEF
                                && i_in.band == BAND_W'(b) && i_in.coef_select <= C_A2;
            w_ctl[b].coef_sel = i_in.coef_select;
            w_ctl[b].coef_val = i_in.coef_value;
            w_ctl[b].hist_clr = accept && i_in.opcode == OP_CLEAR;
        end

        bqe_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[b]),
            .i_active (r_mask[b]),
            .i_link   (w_link[b]),
            .o_link   (w_link[b+1])
        );
    end

    bqe_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_gain),
        .i_link  (w_link[NUM_BANDS]),
        .o_link  (w_gain)
    );

endmodule

// ===== sv/bqe_checker.sv =====
// Port-level checker for the equalizer, bound to the top level.
// Depends on bqe_pkg and biquad_cascade_equalizer_assert.svh.
`include "biquad_cascade_equalizer_assert.svh"

module bqe_checker import bqe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    `BQE_AP_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result beat dropped")
    `BQE_AP_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out), "result beat changed")
    `BQE_AP_NXT(a_one_beat, i_in_valid && o_in_ready, !o_in_ready, "input taken twice in a row")
    `BQE_AP_IMP(a_rise_busy, $rose(o_out_valid), !$past(o_in_ready), "result without work")

endmodule

bind biquad_cascade_equalizer bqe_checker u_bqe_checker (.*);
